// ===== design/mcc_pkg.sv =====
// Shared types and constants for the minimum coin change table.
`default_nettype none

package mcc_pkg;

  // Field widths
  localparam int AmountW = 10;
  localparam int CountW  = 11;
  localparam int KindW   = 2;

  // Default number of table entries
  localparam int AmountDepthDef = 1024;

  // Stored code for an amount that cannot be formed
  localparam logic [CountW-1:0] Unreach = {CountW{1'b1}};

  // Item kinds; the fourth code is unused and ignored
  typedef enum logic [KindW-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_COIN  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  // Input beat
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [AmountW-1:0] coin_value;
    logic [AmountW-1:0] query_amount;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic               reachable;
    logic [AmountW-1:0] coin_count;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic walk_rd;
    logic q_rd;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic walk_last;
    logic coin_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/mcc_datapath.sv =====
// Datapath: count row memory, sweep pointers, update pipeline and result register.
`default_nettype none

module mcc_datapath #(
  parameter int AmountDepth = mcc_pkg::AmountDepthDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire  mcc_pkg::dp_cmd_t         cmd_i,
  output mcc_pkg::dp_stat_t              stat_o,
  input  wire  mcc_pkg::in_item_t        in_data_i,
  input  wire                            cfg_we_i,
  input  wire  [mcc_pkg::AmountW-1:0]    cfg_data_i,
  output mcc_pkg::out_item_t             out_data_o
);

  localparam int AddrW     = (AmountDepth > 1) ? $clog2(AmountDepth) : 1;
  localparam int AmtMaxInt = 2 ** mcc_pkg::AmountW - 1;
  localparam int TopAmtInt = (AmountDepth - 1 > AmtMaxInt) ? AmtMaxInt : AmountDepth - 1;
  localparam logic [mcc_pkg::AmountW-1:0] TopAmt = mcc_pkg::AmountW'(TopAmtInt);

  localparam int AW = mcc_pkg::AmountW;
  localparam int CW = mcc_pkg::CountW;

  logic [CW-1:0]    mem [AmountDepth];

  logic [AW-1:0]    max_amount_q;
  logic [AW-1:0]    cur_q, cur_d;
  logic [AW-1:0]    low_q, low_d;
  logic [AW-1:0]    query_q;
  logic             pv_q;
  logic [AddrW-1:0] wa_q, la_q;
  logic [CW-1:0]    rd_cur_q, rd_low_q;
  logic             fw_vld_q;
  logic [AddrW-1:0] fw_addr_q;
  logic [CW-1:0]    fw_data_q;
  mcc_pkg::out_item_t out_q;

  logic [AW-1:0]    limit;
  logic [AddrW-1:0] cur_addr, low_addr, qry_addr, rda_addr, wr_addr;
  logic [CW-1:0]    low_val, cand, new_val, wr_data;
  logic             wr_en;
  logic             in_range;

  // Highest amount walked or answered
  assign limit = (max_amount_q < TopAmt) ? max_amount_q : TopAmt;

  assign cur_addr = AddrW'(cur_q);
  assign low_addr = AddrW'(low_q);
  assign qry_addr = AddrW'(query_q);

  assign stat_o.clr_last  = (cur_q == TopAmt);
  assign stat_o.walk_last = (cur_q == limit);
  assign stat_o.coin_ok   = (in_data_i.coin_value != '0) && (in_data_i.coin_value <= limit);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_amount_q <= TopAmt | {AW{1'b1}};
    end else if (cfg_we_i) begin
      max_amount_q <= cfg_data_i;
    end
  end

  // Sweep pointers: cur walks the target amount, low trails by the coin value
  always_comb begin
    cur_d = cur_q;
    low_d = low_q;
    if (cmd_i.accept) begin
      cur_d = (in_data_i.kind == mcc_pkg::KIND_COIN) ? in_data_i.coin_value : '0;
      low_d = '0;
    end else if (cmd_i.clr_wr) begin
      cur_d = cur_q + AW'(1);
    end else if (cmd_i.walk_rd) begin
      cur_d = cur_q + AW'(1);
      low_d = low_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      low_q    <= '0;
      pv_q     <= 1'b0;
      fw_vld_q <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      low_q    <= low_d;
      pv_q     <= cmd_i.walk_rd;
      fw_vld_q <= pv_q;
    end
  end

  // Item and pipeline payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      query_q <= in_data_i.query_amount;
    end
    if (cmd_i.walk_rd) begin
      wa_q <= cur_addr;
      la_q <= low_addr;
    end
    fw_addr_q <= wa_q;
    fw_data_q <= new_val;
  end

  // Update stage: take lower entry (forwarded when just written), add one, keep minimum
  always_comb begin
    low_val = (fw_vld_q && (fw_addr_q == la_q)) ? fw_data_q : rd_low_q;
    cand    = (low_val == mcc_pkg::Unreach) ? mcc_pkg::Unreach : low_val + CW'(1);
    new_val = (cand < rd_cur_q) ? cand : rd_cur_q;
  end

  // Write port: clearing sweep or update stage
  assign wr_en   = cmd_i.clr_wr || pv_q;
  assign wr_addr = cmd_i.clr_wr ? cur_addr : wa_q;
  assign wr_data = cmd_i.clr_wr ? ((cur_q == '0) ? '0 : mcc_pkg::Unreach) : new_val;
  assign rda_addr = cmd_i.q_rd ? qry_addr : cur_addr;

  // Row memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.walk_rd || cmd_i.q_rd) begin
      rd_cur_q <= mem[rda_addr];
    end
    if (cmd_i.walk_rd) begin
      rd_low_q <= mem[low_addr];
    end
  end

  // Result register
  assign in_range = (query_q <= limit);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.reachable  <= in_range && !rd_cur_q[CW-1];
      out_q.coin_count <= (in_range && !rd_cur_q[CW-1]) ? rd_cur_q[AW-1:0] : '0;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== design/mcc_ctrl.sv =====
// Controller: sequences clearing sweeps, coin walks and query reads.
`default_nettype none

module mcc_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  [mcc_pkg::KindW-1:0] in_kind_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output mcc_pkg::dp_cmd_t          cmd_o,
  input  wire  mcc_pkg::dp_stat_t   stat_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_QRD,
    S_QOUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Commands and next state
  always_comb begin
    cmd_o         = '0;
    state_d       = state_q;
    cmd_o.accept  = in_valid_i && in_ready_o;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_o.accept) begin
          case (in_kind_i)
            mcc_pkg::KIND_CLEAR: state_d = S_CLEAR;
            mcc_pkg::KIND_COIN:  state_d = stat_i.coin_ok ? S_WALK : S_IDLE;
            mcc_pkg::KIND_QUERY: state_d = S_QRD;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        cmd_o.walk_rd = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_IDLE;
        end
      end
      S_QRD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = S_QOUT;
      end
      S_QOUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result beat holds until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/min_coin_change_table.sv =====
// Query: read the entry (S_QRD), then load the result register once any pending result is taken (S_QOUT).
// Clear: sweeps amounts 0 to N, N = min(1023, AMOUNT_DEPTH-1). Coin of value v under limit L:
// walks amounts v to L, one memory read-modify-write per amount through the single write port.
// One item at a time; a waiting result blocks only a following query.
// Reset is asynchronous, active low; afterwards a clearing pass runs with input ready low,
// configuration writes are taken throughout. max_amount resets to 1023.
`default_nettype none

module min_coin_change_table #(
  parameter int AMOUNT_DEPTH = mcc_pkg::AmountDepthDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  mcc_pkg::in_item_t        in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output mcc_pkg::out_item_t             out_data_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [mcc_pkg::AmountW-1:0]    cfg_data_i
);

  mcc_pkg::dp_cmd_t  cmd;
  mcc_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  mcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_kind_i   (in_data_i.kind),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  mcc_datapath #(
    .AmountDepth (AMOUNT_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

  // Clearing sweep and coin walk never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd.clr_wr && cmd.walk_rd))
    else $error("clear sweep and coin walk active together");

  // No beat is taken while the row is being swept or read for a query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.clr_wr && !cmd.walk_rd && !cmd.q_rd)
    else $error("input ready during table work");

  // A pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

// ===== sim/tb_min_coin_change_table.sv =====
// Testbench for min_coin_change_table: directed table, then random clear/coin/query rounds.
`default_nettype none

module tb_min_coin_change_table;

  localparam int Depth       = mcc_pkg::AmountDepthDef;
  localparam int SettleCyc   = 1100;   // longest walk (clear or coin) plus margin
  localparam logic [mcc_pkg::KindW-1:0] KindUnused = 2'd3;

  // Directed plan row kinds
  typedef enum logic [2:0] {
    OP_CLEAR, OP_COIN, OP_QUERY, OP_NOISE, OP_CFG
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic [mcc_pkg::AmountW-1:0] arg;
    logic                        typed;   // 1: result below is typed in, 0: from the row model
    mcc_pkg::out_item_t          want;
  } plan_row_t;

  localparam int PlanLen = 27;
  localparam plan_row_t Plan [PlanLen] = '{
    {OP_QUERY, 10'd0,    1'b1, 1'b1, 10'd0},     // amount zero right after reset
    {OP_QUERY, 10'd1023, 1'b1, 1'b0, 10'd0},     // top amount unreachable after reset
    {OP_NOISE, 10'h3FF,  1'b0, 1'b0, 10'd0},     // unused kind, all ones
    {OP_COIN,  10'd0,    1'b0, 1'b0, 10'd0},     // zero coin does nothing
    {OP_QUERY, 10'd7,    1'b1, 1'b0, 10'd0},
    {OP_COIN,  10'd1023, 1'b0, 1'b0, 10'd0},     // walks only the top amount
    {OP_QUERY, 10'd1023, 1'b1, 1'b1, 10'd1},
    {OP_COIN,  10'd3,    1'b0, 1'b0, 10'd0},
    {OP_COIN,  10'd5,    1'b0, 1'b0, 10'd0},
    {OP_QUERY, 10'd11,   1'b0, 1'b0, 10'd0},
    {OP_QUERY, 10'd1,    1'b1, 1'b0, 10'd0},     // saturated entry stays unreachable
    {OP_CFG,   10'd1,    1'b0, 1'b0, 10'd0},     // smallest limit a coin can walk under
    {OP_QUERY, 10'd2,    1'b1, 1'b0, 10'd0},     // above the limit
    {OP_COIN,  10'd2,    1'b0, 1'b0, 10'd0},     // coin above the limit
    {OP_COIN,  10'd1,    1'b0, 1'b0, 10'd0},
    {OP_QUERY, 10'd1,    1'b1, 1'b1, 10'd1},
    {OP_CFG,   10'd1023, 1'b0, 1'b0, 10'd0},     // raise limit again
    {OP_QUERY, 10'd1023, 1'b1, 1'b1, 10'd1},
    {OP_QUERY, 10'd2,    1'b1, 1'b0, 10'd0},     // not walked by the last coin
    {OP_QUERY, 10'd1000, 1'b0, 1'b0, 10'd0},
    {OP_CLEAR, 10'd0,    1'b0, 1'b0, 10'd0},
    {OP_QUERY, 10'd1023, 1'b1, 1'b0, 10'd0},
    {OP_COIN,  10'd1,    1'b0, 1'b0, 10'd0},
    {OP_QUERY, 10'd1023, 1'b1, 1'b1, 10'd1023},  // largest count
    {OP_COIN,  10'd512,  1'b0, 1'b0, 10'd0},
    {OP_QUERY, 10'd1023, 1'b0, 1'b0, 10'd0},
    {OP_QUERY, 10'd0,    1'b1, 1'b1, 10'd0}
  };

  // Random phases: limit, sender idle percent, receiver stall percent, useful items
  int unsigned phase_lim   [5] = '{1023, 63, 1023, 1, 700};
  int unsigned phase_idle  [5] = '{0, 75, 0, 23, 23};
  int unsigned phase_stall [5] = '{0, 0, 75, 23, 23};
  int unsigned phase_items [5] = '{110, 110, 110, 60, 110};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  mcc_pkg::in_item_t in_data = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [mcc_pkg::AmountW-1:0] cfg_data = '0;

  logic in_ready, out_valid, cfg_ready;
  mcc_pkg::out_item_t out_data;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fails = 0;
  int unsigned useful_items = 0;

  // Model of the table row and the limit register
  logic [mcc_pkg::CountW-1:0] best_row [Depth];
  logic [mcc_pkg::AmountW-1:0] max_amt;
  mcc_pkg::out_item_t pending_counts [$];

  min_coin_change_table #(.AMOUNT_DEPTH(Depth)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int row_limit();
    return (int'(max_amt) > Depth - 1) ? Depth - 1 : int'(max_amt);
  endfunction

  function automatic void clear_best_row();
    foreach (best_row[i]) best_row[i] = mcc_pkg::Unreach;
    best_row[0] = '0;
  endfunction

  // Applies one item to the row model; returns 1 when the item yields a result
  function automatic bit row_step(input mcc_pkg::in_item_t it,
                                  output mcc_pkg::out_item_t res);
    int lim;
    int cand;
    int e;
    lim = row_limit();
    res = '0;
    case (it.kind)
      mcc_pkg::KIND_CLEAR: begin
        clear_best_row();
        return 1'b0;
      end
      mcc_pkg::KIND_COIN: begin
        if (it.coin_value != 0 && int'(it.coin_value) <= lim) begin
          for (int j = int'(it.coin_value); j <= lim; j++) begin
            cand = int'(best_row[j - int'(it.coin_value)]) + 1;
            if (cand > int'(mcc_pkg::Unreach)) cand = int'(mcc_pkg::Unreach);
            if (cand < int'(best_row[j])) best_row[j] = mcc_pkg::CountW'(cand);
          end
        end
        return 1'b0;
      end
      mcc_pkg::KIND_QUERY: begin
        e = (int'(it.query_amount) <= lim) ? int'(best_row[it.query_amount])
                                           : int'(mcc_pkg::Unreach);
        if (e < int'(mcc_pkg::Unreach) && e < (1 << mcc_pkg::AmountW)) begin
          res.reachable  = 1'b1;
          res.coin_count = mcc_pkg::AmountW'(e);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one beat, with random idle cycles first, and records its outcome at acceptance
  task automatic send_item(input mcc_pkg::in_item_t it, input bit typed,
                           input mcc_pkg::out_item_t want);
    mcc_pkg::out_item_t got;
    bit has;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = row_step(it, got);
    if (has) pending_counts.push_back(typed ? want : got);
  endtask

  // Sender holds off until every pending query has been answered
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0);
  endtask

  // Limit write, only once the block has gone quiet
  task automatic set_limit(input logic [mcc_pkg::AmountW-1:0] lim);
    drain();
    repeat (SettleCyc) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_amt = lim;
  endtask

  // One well-formed round (optional clear, coins, queries) with some noise mixed in
  task automatic random_round();
    mcc_pkg::in_item_t it;
    int lim;
    int n_coins;
    int n_queries;
    int pick;
    lim = row_limit();
    n_coins = $urandom_range(1, 3);
    n_queries = $urandom_range(3, 8);
    if ($urandom_range(3) != 0) begin
      it = mcc_pkg::in_item_t'($urandom);
      it.kind = mcc_pkg::KIND_CLEAR;
      send_item(it, 1'b0, '0);
      useful_items++;
    end
    for (int c = 0; c < n_coins; c++) begin
      it = mcc_pkg::in_item_t'($urandom);
      it.kind = mcc_pkg::KIND_COIN;
      if ($urandom_range(4) != 0)
        it.coin_value = mcc_pkg::AmountW'($urandom_range(1, (lim < 12) ? lim : 12));
      else
        it.coin_value = mcc_pkg::AmountW'($urandom_range(1, lim));
      send_item(it, 1'b0, '0);
      useful_items++;
    end
    for (int q = 0; q < n_queries; q++) begin
      it = mcc_pkg::in_item_t'($urandom);
      it.kind = mcc_pkg::KIND_QUERY;
      pick = $urandom_range(99);
      if (pick < 70)      it.query_amount = mcc_pkg::AmountW'($urandom_range(0, lim));
      else if (pick < 85) it.query_amount = mcc_pkg::AmountW'($urandom_range(lim, 1023));
      send_item(it, 1'b0, '0);
      useful_items++;
    end
    // noise: unused kind, zero coin, or coin past the limit
    if ($urandom_range(9) == 0) begin
      it = mcc_pkg::in_item_t'($urandom);
      pick = $urandom_range(2);
      if (pick == 0) begin
        it.kind = KindUnused;
      end else begin
        it.kind = mcc_pkg::KIND_COIN;
        it.coin_value = (pick == 1 || lim == 1023) ? '0
                      : mcc_pkg::AmountW'($urandom_range(lim + 1, 1023));
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // Receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Result checking against the oldest pending count
  always @(posedge clk) begin : check_counts
    mcc_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_counts.size() == 0) begin
        $error("result with none pending: reachable %0d coin_count %0d",
               out_data.reachable, out_data.coin_count);
        fails++;
      end else begin
        want = pending_counts.pop_front();
        if (out_data.reachable !== want.reachable) begin
          $error("reachable: expected %0d, got %0d", want.reachable, out_data.reachable);
          fails++;
        end
        if (out_data.coin_count !== want.coin_count) begin
          $error("coin_count: expected %0d, got %0d", want.coin_count, out_data.coin_count);
          fails++;
        end
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    mcc_pkg::in_item_t it;
    max_amt = 10'd1023;
    clear_best_row();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan
    foreach (Plan[i]) begin
      if (Plan[i].op == OP_CFG) begin
        set_limit(Plan[i].arg);
      end else begin
        it.coin_value   = Plan[i].arg;
        it.query_amount = Plan[i].arg;
        case (Plan[i].op)
          OP_CLEAR: it.kind = mcc_pkg::KIND_CLEAR;
          OP_COIN:  it.kind = mcc_pkg::KIND_COIN;
          OP_QUERY: it.kind = mcc_pkg::KIND_QUERY;
          default:  it.kind = KindUnused;
        endcase
        send_item(it, Plan[i].typed, Plan[i].want);
      end
    end

    // Random phases
    for (int p = 0; p < 5; p++) begin
      set_limit(mcc_pkg::AmountW'(phase_lim[p]));
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      useful_items = 0;
      while (useful_items < phase_items[p]) begin
        random_round();
        if ($urandom_range(29) == 0) drain();
      end
    end

    drain();
    repeat (SettleCyc) @(posedge clk);
    if (fails == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #64000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
